// ===== design/decimating_fir_filter_core_macros.svh =====
`ifndef DECIMATING_FIR_FILTER_CORE_MACROS_SVH
`define DECIMATING_FIR_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DECFIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimating FIR check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DECFIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimating FIR check failed");

`endif

// ===== design/decfir_pkg.sv =====
package decfir_pkg;

    localparam int MAX_TAPS_DEF     = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int TAP_COUNT_W = 7;
    localparam int DECIM_W     = 16;
    localparam int TAP_INDEX_W = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int TAP_COUNT_RESET = 64;
    localparam int DECIM_RESET     = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 1'b1;

    // Input item modes.
    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_TAP_WRITE = 1'b1;

    typedef struct packed {
        logic sample_wr;
        logic tap_wr;
        logic start;
        logic issue;
        logic out_load;
    } decfir_cmd_t;

    typedef struct packed {
        logic fire;
        logic last_tap;
        logic pipe_empty;
        logic out_free;
    } decfir_status_t;

endpackage

// ===== design/decfir_item_if.sv =====
interface decfir_item_if
    import decfir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [TAP_INDEX_W-1:0]         tap_index;
    logic signed [SAMPLE_WIDTH-1:0] value;

    modport source (output valid, output mode, output tap_index, output value, input ready);
    modport sink (input valid, input mode, input tap_index, input value, output ready);
endinterface

// ===== design/decfir_result_if.sv =====
interface decfir_result_if
    import decfir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_out;
    logic                           saturated;

    modport source (output valid, output filtered_out, output saturated, input ready);
    modport sink (input valid, input filtered_out, input saturated, output ready);
endinterface

// ===== design/decimating_fir_filter_core.sv =====
// Tap writes and samples that give no result are accepted back to back while the core is idle.
// A sample that gives a result starts the single multiply-accumulate unit, which walks the taps
// one per cycle; the sum then drains into the output register once that register is free.
// The result waits in an output register; new items are accepted while it waits.
// Reset (rst_n, asynchronous, active low) empties the delay line through a fill count, so no
// clearing pass is needed; tap_count resets to 64, decimation_factor to 1, taps stay unwritten.
module decimating_fir_filter_core
    import decfir_pkg::*;
#(
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    decfir_item_if.sink            items,
    decfir_result_if.source        results,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "decimating_fir_filter_core_macros.svh"

    decfir_cmd_t    cmd;
    decfir_status_t status;
    logic           in_ready;

    assign items.ready = in_ready;

    decfir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_mode  (items.mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    decfir_datapath #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_tap_index  (items.tap_index),
        .in_value      (items.value),
        .out_ready     (results.ready),
        .out_valid     (results.valid),
        .out_filtered  (results.filtered_out),
        .out_saturated (results.saturated)
    );

    // No input beat while the tap walk is running.
    `DECFIR_ASSERT_NOW(a_no_accept_in_mac, cmd.issue, !in_ready)
    // The walk stops after the last tap.
    `DECFIR_ASSERT_NEXT(a_walk_ends, cmd.issue && status.last_tap, !cmd.issue)
    // A loaded result is offered on the next cycle.
    `DECFIR_ASSERT_NEXT(a_result_offered, cmd.out_load, results.valid)

endmodule

// ===== design/decfir_ctrl.sv =====
module decfir_ctrl
    import decfir_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    input  decfir_status_t status,
    output decfir_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.sample_wr = in_valid && (in_mode == MODE_SAMPLE);
                cmd.tap_wr    = in_valid && (in_mode == MODE_TAP_WRITE);
                cmd.start     = cmd.sample_wr && status.fire;
                if (cmd.start)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The sum is complete once the read and multiply stages are empty.
                if (status.pipe_empty && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/decfir_datapath.sv =====
module decfir_datapath
    import decfir_pkg::*;
#(
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  decfir_cmd_t                    cmd,
    output decfir_status_t                 status,
    input  logic                           cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic [TAP_INDEX_W-1:0]         in_tap_index,
    input  logic signed [SAMPLE_WIDTH-1:0] in_value,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
    output logic                           out_saturated
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int NW     = (CNT_W > TAP_COUNT_W) ? CNT_W : TAP_COUNT_W;
    localparam int TIW    = ((IDX_W > TAP_INDEX_W) ? IDX_W : TAP_INDEX_W) + 1;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 8;
    localparam int FRAC   = SAMPLE_WIDTH - 1;
    localparam int N_RESET = (MAX_TAPS < TAP_COUNT_RESET) ? MAX_TAPS : TAP_COUNT_RESET;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-FRAC){1'b0}}, {FRAC{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-FRAC){1'b1}}, {FRAC{1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF   =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    // Sample and coefficient stores.
    logic signed [SAMPLE_WIDTH-1:0] dl_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] tap_mem [MAX_TAPS];

    logic [CNT_W-1:0]   n_reg;
    logic [DECIM_W-1:0] dec_reg;
    logic [IDX_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [DECIM_W-1:0] phase_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   tap_addr_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               rd_ok_reg;
    logic               out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] dl_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] tap_rd_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;
    logic                           out_sat_reg;

    logic [NW-1:0]          tc_ext;
    logic [CNT_W-1:0]       n_cfg;
    logic [CNT_W-1:0]       wp_inc;
    logic [IDX_W-1:0]       wp_next;
    logic [CNT_W-1:0]       rd_inc;
    logic [IDX_W-1:0]       rd_next;
    logic [DECIM_W:0]       phase_inc;
    logic [DECIM_W-1:0]     phase_next;
    logic                   tap_in_range;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;

    always_comb
    begin
        tc_ext = NW'(cfg_data[TAP_COUNT_W-1:0]);
        if (tc_ext == '0)
        begin
            n_cfg = CNT_W'(1);
        end
        else if (tc_ext > NW'(MAX_TAPS))
        begin
            n_cfg = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_cfg = CNT_W'(tc_ext);
        end
    end

    assign wp_inc  = CNT_W'(wp_reg) + CNT_W'(1);
    assign wp_next = (wp_inc == n_reg) ? '0 : IDX_W'(wp_inc);
    assign rd_inc  = CNT_W'(rd_ptr_reg) + CNT_W'(1);
    assign rd_next = (rd_inc == n_reg) ? '0 : IDX_W'(rd_inc);

    // A zero factor behaves as one: the phase falls back to zero on every sample.
    assign phase_inc  = {1'b0, phase_reg} + (DECIM_W+1)'(1);
    assign phase_next = (phase_inc >= {1'b0, dec_reg}) ? '0 : DECIM_W'(phase_inc);

    assign tap_in_range = TIW'(in_tap_index) < TIW'(MAX_TAPS);

    assign rounded = acc_reg + HALF;
    assign shifted = rounded >>> FRAC;

    assign status.fire       = (phase_reg == '0);
    assign status.last_tap   = (CNT_W'(tap_addr_reg) + CNT_W'(1)) == n_reg;
    assign status.pipe_empty = !v1_reg && !v2_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_filtered  = out_data_reg;
    assign out_saturated = out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sample_wr)
        begin
            dl_mem[wp_reg] <= in_value;
        end
        if (cmd.issue)
        begin
            dl_rd_reg <= dl_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tap_wr && tap_in_range)
        begin
            tap_mem[IDX_W'(in_tap_index)] <= in_value;
        end
        if (cmd.issue)
        begin
            tap_rd_reg <= tap_mem[tap_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            // Entries not written since the last clear read as zero.
            rd_ok_reg <= CNT_W'(rd_ptr_reg) < fill_reg;
        end
        if (v1_reg)
        begin
            prod_reg <= rd_ok_reg ? PROD_W'(dl_rd_reg * tap_rd_reg) : '0;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.start)
        begin
            rd_ptr_reg   <= wp_next;
            tap_addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            rd_ptr_reg   <= rd_next;
            tap_addr_reg <= IDX_W'(CNT_W'(tap_addr_reg) + CNT_W'(1));
        end
        if (cmd.out_load)
        begin
            if (shifted > SAT_HI)
            begin
                out_data_reg <= SAMPLE_WIDTH'(SAT_HI);
                out_sat_reg  <= 1'b1;
            end
            else if (shifted < SAT_LO)
            begin
                out_data_reg <= SAMPLE_WIDTH'(SAT_LO);
                out_sat_reg  <= 1'b1;
            end
            else
            begin
                out_data_reg <= SAMPLE_WIDTH'(shifted);
                out_sat_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_W'(N_RESET);
            dec_reg       <= DECIM_W'(DECIM_RESET);
            wp_reg        <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TAP_COUNT:
                    begin
                        n_reg <= n_cfg;
                    end
                    REG_DECIMATION:
                    begin
                        dec_reg <= cfg_data[DECIM_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                // Any register write restarts the delay line and the phase.
                wp_reg    <= '0;
                fill_reg  <= '0;
                phase_reg <= '0;
            end
            else if (cmd.sample_wr)
            begin
                wp_reg    <= wp_next;
                fill_reg  <= (fill_reg == n_reg) ? fill_reg : fill_reg + CNT_W'(1);
                phase_reg <= phase_next;
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import decfir_pkg::*;

    localparam int NTAPS       = MAX_TAPS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 80;
    localparam int DIR_ROWS    = 21;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 80;
    localparam int RAND_ITEMS  = PHASES * PHASE_ITEMS;

    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] y;
        logic               sat;
    } fir_out_t;

    typedef struct packed {
        logic               mode;
        logic [5:0]         idx;
        logic signed [15:0] value;
        logic               typed;
        fir_out_t           want;
    } vector_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    decfir_item_if   items_if ();
    decfir_result_if results_if ();

    decimating_fir_filter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the filter state.
    logic signed [15:0] history [NTAPS];
    logic signed [15:0] coeffs [NTAPS];
    int                 head;
    int                 phase_cnt;
    logic [6:0]         tap_count_reg;
    logic [15:0]        dec_reg;

    fir_out_t awaited_outputs [$];
    int       mismatches;
    int       cycle_count;
    int       tx_idle_pct;
    int       rx_idle_pct;

    // Taps are zero on entry; until the last typed row only slots 61 to 63 are loaded, so each
    // typed result is a sum of one to three products.
    vector_t directed_rows [DIR_ROWS] = '{
        '{MODE_TAP_WRITE, 6'd63, Q_MIN,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b1, '{Q_MAX,      1'b1}},
        '{MODE_SAMPLE,    6'd0,  Q_MAX,        1'b1, '{16'sh8001, 1'b0}},
        '{MODE_TAP_WRITE, 6'd63, 16'sh0001,    1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  16'sh4000,    1'b1, '{16'sh0001, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  16'shC000,    1'b1, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  16'shBFFF,    1'b1, '{16'shFFFF, 1'b0}},
        '{MODE_TAP_WRITE, 6'd62, Q_MIN,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b1, '{16'sh4000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b1, '{Q_MAX,      1'b0}},
        '{MODE_TAP_WRITE, 6'd61, Q_MIN,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b1, '{Q_MAX,      1'b1}},
        '{MODE_TAP_WRITE, 6'd63, Q_MAX,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_TAP_WRITE, 6'd62, Q_MAX,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_TAP_WRITE, 6'd61, Q_MAX,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd0,  Q_MIN,        1'b1, '{Q_MIN,      1'b1}},
        '{MODE_TAP_WRITE, 6'd0,  Q_MAX,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd21, Q_MAX,        1'b0, '{16'sh0000, 1'b0}},
        '{MODE_TAP_WRITE, 6'd42, 16'sh5A5A,    1'b0, '{16'sh0000, 1'b0}},
        '{MODE_SAMPLE,    6'd42, 16'sh2A5C,    1'b0, '{16'sh0000, 1'b0}}
    };

    int phase_taps [PHASES] = '{1, 0, 127, 64, 2, 8, 33, 64, 3, 16, -1, -1};
    int phase_decs [PHASES] = '{1, 0, 2, 3, 65535, 1, 5, 1, 7, 2, -1, -1};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("decimating_fir_filter_core verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        results_if.ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_outputs
        fir_out_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (awaited_outputs.size() == 0)
                report_mismatch("result beat with nothing pending", results_if.filtered_out, 0);
            else
            begin
                want = awaited_outputs.pop_front();
                if (results_if.filtered_out !== want.y)
                    report_mismatch("filtered_out", results_if.filtered_out, want.y);
                if (results_if.saturated !== want.sat)
                    report_mismatch("saturated", results_if.saturated, want.sat);
            end
        end
    end

    task automatic clear_history();
        int i;
        for (i = 0; i < NTAPS; i++)
            history[i] = '0;
        head = 0;
        phase_cnt = 0;
    endtask

    // Advances the shadow state by one item; returns 1 when a result is due.
    function automatic bit run_filter(input logic m, input logic [5:0] ti,
                                      input logic signed [15:0] v, output fir_out_t r);
        int      n;
        int      dec;
        int      k;
        bit      fire;
        longint  acc;
        longint  shifted;
        r = '0;
        n = (tap_count_reg == 0) ? 1 : ((tap_count_reg > NTAPS) ? NTAPS : int'(tap_count_reg));
        dec = (dec_reg == 0) ? 1 : int'(dec_reg);
        if (m == MODE_TAP_WRITE)
        begin
            coeffs[ti] = v;
            return 1'b0;
        end
        head = head % n;
        history[head] = v;
        head = (head + 1) % n;
        fire = (phase_cnt == 0);
        phase_cnt++;
        if (phase_cnt >= dec)
            phase_cnt = 0;
        if (!fire)
            return 1'b0;
        // After the write, head points at the oldest sample, which tap 0 weights.
        acc = 0;
        for (k = 0; k < n; k++)
            acc += longint'(history[(head + k) % n]) * longint'(coeffs[k]);
        shifted = (acc + 64'sd16384) >>> 15;
        if (shifted > 32767)
            r = '{Q_MAX, 1'b1};
        else if (shifted < -32768)
            r = '{Q_MIN, 1'b1};
        else
            r = '{shifted[15:0], 1'b0};
        return 1'b1;
    endfunction

    task automatic send_item(input logic m, input logic [5:0] ti, input logic signed [15:0] v,
                             input logic typed, input fir_out_t typed_out);
        int       gap;
        fir_out_t r;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_if.valid     <= 1'b1;
        items_if.mode      <= m;
        items_if.tap_index <= ti;
        items_if.value     <= v;
        do
            @(posedge clk);
        while (!items_if.ready);
        if (run_filter(m, ti, v, r) || typed)
            awaited_outputs.push_back(typed ? typed_out : r);
    endtask

    task automatic finish_phase();
        @(negedge clk);
        items_if.valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        // A trailing tap write or silent sample may still be in flight.
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TAP_COUNT)
            tap_count_reg = data[6:0];
        else if (idx == REG_DECIMATION)
            dec_reg = data;
        clear_history();
    endtask

    function automatic logic signed [15:0] draw_value();
        int c;
        c = $urandom_range(99);
        if (c < 8)
            return Q_MAX;
        else if (c < 16)
            return Q_MIN;
        else if (c < 50)
            return 16'($urandom_range(1023)) - 16'sd512;
        return 16'($urandom);
    endfunction

    initial
    begin
        int       i;
        int       p;
        int       j;
        int       sent;
        int       taps;
        int       dec;
        vector_t  row;
        logic     m;

        items_if.valid     = 1'b0;
        items_if.mode      = MODE_SAMPLE;
        items_if.tap_index = '0;
        items_if.value     = '0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_TAP_COUNT;
        cfg_data           = '0;
        rst_n              = 1'b0;
        tx_idle_pct        = 28;
        rx_idle_pct        = 47;

        tap_count_reg = 7'(TAP_COUNT_RESET);
        dec_reg       = 16'(DECIM_RESET);
        clear_history();
        for (i = 0; i < NTAPS; i++)
            coeffs[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every tap is written before the first sample reads it.
        for (i = 0; i < NTAPS; i++)
            send_item(MODE_TAP_WRITE, 6'(i), 16'sh0000, 1'b0, '0);

        for (j = 0; j < DIR_ROWS; j++)
        begin
            row = directed_rows[j];
            send_item(row.mode, row.idx, row.value, row.typed, row.want);
        end
        finish_phase();

        sent = 0;
        for (p = 0; p < PHASES; p++)
        begin
            taps = (phase_taps[p] < 0) ? $urandom_range(127) : phase_taps[p];
            dec  = (phase_decs[p] < 0) ? $urandom_range(9) : phase_decs[p];
            write_register(REG_TAP_COUNT, {9'($urandom), 7'(taps)});
            write_register(REG_DECIMATION, 16'(dec));
            for (j = 0; j < PHASE_ITEMS; j++)
            begin
                case (sent * 3 / RAND_ITEMS)
                    0:
                    begin
                        tx_idle_pct = 28;
                        rx_idle_pct = 47;
                    end
                    1:
                    begin
                        tx_idle_pct = 47;
                        rx_idle_pct = 28;
                    end
                    default:
                    begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                m = ($urandom_range(99) < 20) ? MODE_TAP_WRITE : MODE_SAMPLE;
                send_item(m, 6'($urandom_range(63)), draw_value(), 1'b0, '0);
                sent++;
            end
            finish_phase();
        end

        if (mismatches == 0)
            $display("decimating_fir_filter_core verification clean");
        else
            $display("decimating_fir_filter_core verification failed");
        $finish;
    end

endmodule
